// ===== src/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Shared widths, codes and item types for the block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   // Pool geometry.
   localparam int MAX_BLOCKS = 1024;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int LINK_W     = IDX_W + 1;
   localparam int COUNT_W    = 11;
   localparam int SIZE_W     = 17;
   localparam int UNITS_W    = 13;
   localparam int OFFSET_W   = 26;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIZE_W;

   // End-of-list mark stored in the link table.
   localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_BLOCKS);

   // Register reset values and limits.
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
   localparam logic [COUNT_W-1:0] COUNT_CAP   = COUNT_W'(MAX_BLOCKS);
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(16);
   localparam logic [SIZE_W-1:0]  SIZE_CAP    = SIZE_W'(65536);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = CSR_IDX_W'(1);

   // Request codes.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Status codes.
   localparam logic [1:0] STAT_ALLOCATED = 2'd0;
   localparam logic [1:0] STAT_EMPTY     = 2'd1;
   localparam logic [1:0] STAT_FREED     = 2'd2;
   localparam logic [1:0] STAT_IGNORED   = 2'd3;

   // Input item.
   typedef struct packed {
      logic             req_type;
      logic [IDX_W-1:0] free_index;
   } req_item_type;

   // Result item.
   typedef struct packed {
      logic [1:0]          status;
      logic [IDX_W-1:0]    block_index;
      logic [OFFSET_W-1:0] byte_offset;
      logic [COUNT_W-1:0]  free_left;
   } rsp_item_type;

   // Derived configuration handed from the register block to the control.
   typedef struct packed {
      logic [COUNT_W-1:0] eff_count;
      logic [UNITS_W-1:0] size_units;
      logic               rebuild;
   } cfg_type;

endpackage

// ===== src/fixed_block_pool_allocator.sv =====
// An item taken in idle is registered along with the link RAM read of the
// head; the exec state forms the result, which is registered, and no new
// item is taken before exec is left. Reset and every count or size write
// start a sweep that rebuilds the link table; busy stays high meanwhile.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Free-list allocator of fixed-size blocks with the links held in a RAM.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  fbpa_pkg::req_item_type          req_data,
   output logic                            rsp_valid,
   output fbpa_pkg::rsp_item_type          rsp_data,
   input  logic                            csr_we,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   fbpa_pkg::cfg_type             cfg;
   logic                          ram_we;
   logic [fbpa_pkg::IDX_W-1:0]    ram_waddr;
   logic [fbpa_pkg::LINK_W-1:0]   ram_wdata;
   logic [fbpa_pkg::IDX_W-1:0]    ram_raddr;
   logic [fbpa_pkg::LINK_W-1:0]   ram_rdata;

   // Configuration registers.
   fbpa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Free-list control.
   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // Next-link table.
   fbpa_ram #(
      .ADDR_W (fbpa_pkg::IDX_W),
      .DATA_W (fbpa_pkg::LINK_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

// ===== src/fbpa_ram.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool link RAM
// Simple dual-port synchronous RAM with one write port and one registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fbpa_csr.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool configuration registers
// Holds the pool registers, derives the clamped count and the size in
// 16-byte units, and flags a table rebuild after every accepted write.
// ----------------------------------------------------------------------------
module fbpa_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output fbpa_pkg::cfg_type               cfg
);

   logic [fbpa_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [fbpa_pkg::SIZE_W-1:0]  size_ff, size_in;
   logic                         rebuild_ff, rebuild_in;
   logic [fbpa_pkg::SIZE_W-1:0]  size_sat;
   logic [fbpa_pkg::SIZE_W-1:0]  size_round;

   // Register writes; a write to an unknown index changes nothing.
   always_comb begin
      count_in   = count_ff;
      size_in    = size_ff;
      rebuild_in = 1'b0;
      if (csr_we) begin
         case (csr_index)
            fbpa_pkg::CSR_BLOCK_COUNT: begin
               count_in   = csr_wdata[fbpa_pkg::COUNT_W-1:0];
               rebuild_in = 1'b1;
            end
            fbpa_pkg::CSR_BLOCK_SIZE: begin
               size_in    = csr_wdata;
               rebuild_in = 1'b1;
            end
            default: begin
               rebuild_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= fbpa_pkg::COUNT_RESET;
         size_ff    <= fbpa_pkg::SIZE_RESET;
         rebuild_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         size_ff    <= size_in;
         rebuild_ff <= rebuild_in;
      end
   end

   // Clamp the size, then round up to the next multiple of 16.
   assign size_sat   = (size_ff > fbpa_pkg::SIZE_CAP) ? fbpa_pkg::SIZE_CAP : size_ff;
   assign size_round = size_sat + fbpa_pkg::SIZE_W'(15);

   assign cfg.eff_count  = (count_ff > fbpa_pkg::COUNT_CAP) ? fbpa_pkg::COUNT_CAP : count_ff;
   assign cfg.size_units = size_round[fbpa_pkg::SIZE_W-1:4];
   assign cfg.rebuild    = rebuild_ff;

endmodule

// ===== src/fbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool control
// Runs the table rebuild sweep and the read-modify-write of the free list
// for each allocate or free item, and registers the result item.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  fbpa_pkg::cfg_type             cfg,
   input  logic                          start,
   output logic                          busy,
   input  fbpa_pkg::req_item_type        req_data,
   output logic                          rsp_valid,
   output fbpa_pkg::rsp_item_type        rsp_data,
   output logic                          ram_we,
   output logic [fbpa_pkg::IDX_W-1:0]    ram_waddr,
   output logic [fbpa_pkg::LINK_W-1:0]   ram_wdata,
   output logic [fbpa_pkg::IDX_W-1:0]    ram_raddr,
   input  logic [fbpa_pkg::LINK_W-1:0]   ram_rdata
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   localparam int PROD_W = fbpa_pkg::IDX_W + fbpa_pkg::UNITS_W;

   logic [1:0]                    state_ff, state_in;
   logic [fbpa_pkg::IDX_W-1:0]    clr_ff, clr_in;
   logic [fbpa_pkg::LINK_W-1:0]   head_ff, head_in;
   logic [fbpa_pkg::COUNT_W-1:0]  count_ff, count_in;
   fbpa_pkg::req_item_type        req_ff, req_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   fbpa_pkg::rsp_item_type        rsp_ff, rsp_in;

   logic [fbpa_pkg::LINK_W-1:0]   clr_next;
   logic [fbpa_pkg::LINK_W-1:0]   clr_link;
   logic                          alloc_ok;
   logic                          free_ok;
   logic [PROD_W-1:0]             prod;

   // Link value the rebuild sweep writes at the current entry.
   assign clr_next = {1'b0, clr_ff} + fbpa_pkg::LINK_W'(1);
   assign clr_link = (clr_next < cfg.eff_count) ? clr_next : fbpa_pkg::END_MARK;

   // Pop and push conditions.
   assign alloc_ok = (count_ff != '0) && (head_ff < cfg.eff_count);
   assign free_ok  = ({1'b0, req_ff.free_index} < cfg.eff_count);

   // Offset in 16-byte units of the head block.
   assign prod = PROD_W'(head_ff[fbpa_pkg::IDX_W-1:0]) * PROD_W'(cfg.size_units);

   // The head's link is read while the item is taken in.
   assign ram_raddr = head_ff[fbpa_pkg::IDX_W-1:0];

   // Next-state and datapath logic.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = clr_link;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + fbpa_pkg::IDX_W'(1);
            if (clr_ff == fbpa_pkg::IDX_W'(fbpa_pkg::MAX_BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in           = ST_IDLE;
            rsp_valid_in       = 1'b1;
            rsp_in.block_index = '0;
            rsp_in.byte_offset = '0;
            if (req_ff.req_type == fbpa_pkg::REQ_ALLOC) begin
               if (alloc_ok) begin
                  head_in            = ram_rdata;
                  count_in           = count_ff - fbpa_pkg::COUNT_W'(1);
                  rsp_in.status      = fbpa_pkg::STAT_ALLOCATED;
                  rsp_in.block_index = head_ff[fbpa_pkg::IDX_W-1:0];
                  rsp_in.byte_offset = {prod[fbpa_pkg::OFFSET_W-5:0], 4'b0000};
               end else begin
                  rsp_in.status = fbpa_pkg::STAT_EMPTY;
               end
            end else begin
               if (free_ok) begin
                  ram_we    = 1'b1;
                  ram_waddr = req_ff.free_index;
                  ram_wdata = head_ff;
                  head_in   = {1'b0, req_ff.free_index};
                  if (count_ff < cfg.eff_count) begin
                     count_in = count_ff + fbpa_pkg::COUNT_W'(1);
                  end
                  rsp_in.status = fbpa_pkg::STAT_FREED;
               end else begin
                  rsp_in.status = fbpa_pkg::STAT_IGNORED;
               end
            end
            rsp_in.free_left = count_in;
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase

      // A register write restarts the sweep with the new pool size.
      if (cfg.rebuild) begin
         state_in = ST_CLEAR;
         clr_in   = '0;
         head_in  = '0;
         count_in = cfg.eff_count;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         count_ff     <= fbpa_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE) || cfg.rebuild;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/fbpa_checker.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool port checker
// Watches the allocator's ports for timing and result consistency.
// ----------------------------------------------------------------------------
module fbpa_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input fbpa_pkg::rsp_item_type rsp_data
);

   // Every accepted item yields its result after the exec state and result register.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("result missing two cycles after an accepted item");

   // A result only follows an accepted item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without an accepted item");

   // An item is being worked on in the cycle after it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy while working on an item");

   // Results that allocate nothing carry zero index and offset.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != fbpa_pkg::STAT_ALLOCATED)) |->
         ((rsp_data.block_index == '0) && (rsp_data.byte_offset == '0)))
      else $error("nonzero index or offset without an allocation");

   // Offsets are aligned to 16 bytes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.byte_offset[3:0] == 4'b0000))
      else $error("byte offset not aligned to 16");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
